@@ rtl/edp_pkg.sv @@
// Shared types and constants for the padded Euclidean distance block.
package edp_pkg;

  localparam int unsigned ElemW  = 16;
  localparam int unsigned SqW    = 33;
  localparam int unsigned AccW   = 38;
  localparam int unsigned DistW  = 19;
  localparam int unsigned RootW  = 40;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [AccW-1:0] AccMax = {AccW{1'b1}};

  // one finished vector handed from front to back
  typedef struct packed {
    logic [AccW-1:0] sum;
    logic            ovf;
  } vec_sum_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DONE
  } bk_state_e;

endpackage

@@ rtl/edp_front.sv @@
// Front end: takes component pairs, squares differences, accumulates per vector.
module edp_front #(
  parameter int unsigned MAX_DIM = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [edp_pkg::ElemW-1:0] a_elem_i,
  input  logic signed [edp_pkg::ElemW-1:0] b_elem_i,
  input  logic                          a_present_i,
  input  logic                          b_present_i,
  input  logic                          last_i,
  input  edp_pkg::q_stat_t              q_stat_i,
  output logic                          push_o,
  output edp_pkg::vec_sum_t             push_data_o
);

  localparam int unsigned CntW = $clog2(MAX_DIM + 1);

  logic                            in_acc;
  logic signed [edp_pkg::ElemW:0]  a_ext, b_ext, diff;
  logic [edp_pkg::ElemW:0]         abs_diff;
  logic [2*edp_pkg::ElemW+1:0]     sq_full;

  logic                            sa_vld_q, sa_vld_d;
  logic                            sa_last_q;
  logic [edp_pkg::SqW-1:0]         sa_sq_q;
  logic                            b_take;

  logic [edp_pkg::AccW-1:0]        acc_q, acc_d, acc_n;
  logic [CntW-1:0]                 cnt_q, cnt_d, cnt_n;
  logic                            ovf_q, ovf_d, ovf_n;
  logic [edp_pkg::AccW:0]          sum_wide;

  assign in_acc = in_valid_i && !in_stall_o;

  // absent component reads as zero
  assign a_ext    = a_present_i ? {a_elem_i[edp_pkg::ElemW-1], a_elem_i} : '0;
  assign b_ext    = b_present_i ? {b_elem_i[edp_pkg::ElemW-1], b_elem_i} : '0;
  assign diff     = a_ext - b_ext;
  assign abs_diff = diff[edp_pkg::ElemW] ? 17'(-diff) : 17'(diff);
  assign sq_full  = abs_diff * abs_diff;

  // stage B drains unless a vector end has nowhere to go
  assign b_take     = sa_vld_q && !(sa_last_q && q_stat_i.full);
  assign in_stall_o = sa_vld_q && !b_take;

  always_comb begin
    if (in_acc) begin
      sa_vld_d = 1'b1;
    end else if (b_take) begin
      sa_vld_d = 1'b0;
    end else begin
      sa_vld_d = sa_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_vld_q <= 1'b0;
    end else begin
      sa_vld_q <= sa_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sa_sq_q   <= sq_full[edp_pkg::SqW-1:0];
      sa_last_q <= last_i;
    end
  end

  // saturating accumulate, count past MAX_DIM pins the sum
  assign sum_wide = {1'b0, acc_q} + (edp_pkg::AccW + 1)'(sa_sq_q);

  always_comb begin
    acc_n = acc_q;
    cnt_n = cnt_q;
    ovf_n = ovf_q;
    if (cnt_q >= CntW'(MAX_DIM)) begin
      ovf_n = 1'b1;
      acc_n = edp_pkg::AccMax;
    end else begin
      cnt_n = cnt_q + CntW'(1);
      if (!ovf_q) begin
        acc_n = sum_wide[edp_pkg::AccW] ? edp_pkg::AccMax : sum_wide[edp_pkg::AccW-1:0];
      end
    end
  end

  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (b_take) begin
      if (sa_last_q) begin
        acc_d = '0;
        cnt_d = '0;
        ovf_d = 1'b0;
      end else begin
        acc_d = acc_n;
        cnt_d = cnt_n;
        ovf_d = ovf_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

  assign push_o          = b_take && sa_last_q;
  assign push_data_o.sum = acc_n;
  assign push_data_o.ovf = ovf_n;

endmodule

@@ rtl/edp_fifo.sv @@
// Short queue of finished vector sums between front and back.
module edp_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  edp_pkg::vec_sum_t push_data_i,
  input  logic              pop_i,
  output edp_pkg::vec_sum_t pop_data_o,
  output edp_pkg::q_stat_t  stat_o
);

  edp_pkg::vec_sum_t              mem_q [edp_pkg::QDepth];
  logic [edp_pkg::QPtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [edp_pkg::QPtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [edp_pkg::QCntW-1:0]      cnt_q, cnt_d;
  logic                           do_push, do_pop;

  assign stat_o.full  = (cnt_q == edp_pkg::QCntW'(edp_pkg::QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == edp_pkg::QPtrW'(edp_pkg::QDepth - 1)) ? '0
                 : wr_ptr_q + edp_pkg::QPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == edp_pkg::QPtrW'(edp_pkg::QDepth - 1)) ? '0
                 : rd_ptr_q + edp_pkg::QPtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + edp_pkg::QCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - edp_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/edp_back.sv @@
// Back end: bit-pair integer square root per vector and the output register.
module edp_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  edp_pkg::q_stat_t            q_stat_i,
  input  edp_pkg::vec_sum_t           pop_data_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [edp_pkg::DistW-1:0]   distance_o,
  output logic [edp_pkg::AccW-1:0]    sum_of_squares_o,
  output logic                        overflow_o
);

  localparam logic [edp_pkg::RootW-1:0] BitInit =
    edp_pkg::RootW'(1) << (edp_pkg::AccW);

  edp_pkg::bk_state_e state_q, state_d;

  logic [edp_pkg::AccW-1:0]   rem_q, rem_d;
  logic [edp_pkg::RootW-1:0]  res_q, res_d;
  logic [edp_pkg::RootW-1:0]  bit_q, bit_d;
  logic [edp_pkg::AccW-1:0]   sum_q, sum_d;
  logic                       ovf_q, ovf_d;
  logic [edp_pkg::RootW-1:0]  trial, rem_ext;

  logic                       out_vld_q, out_vld_d;
  logic [edp_pkg::DistW-1:0]  dist_q, dist_d;
  logic [edp_pkg::AccW-1:0]   osum_q, osum_d;
  logic                       oovf_q, oovf_d;
  logic                       out_free;

  assign out_free = !out_vld_q || !out_stall_i;
  assign trial    = res_q + bit_q;
  assign rem_ext  = {{(edp_pkg::RootW - edp_pkg::AccW){1'b0}}, rem_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= edp_pkg::BK_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    res_q  <= res_d;
    bit_q  <= bit_d;
    sum_q  <= sum_d;
    ovf_q  <= ovf_d;
    dist_q <= dist_d;
    osum_q <= osum_d;
    oovf_q <= oovf_d;
  end

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    rem_d     = rem_q;
    res_d     = res_q;
    bit_d     = bit_q;
    sum_d     = sum_q;
    ovf_d     = ovf_q;
    dist_d    = dist_q;
    osum_d    = osum_q;
    oovf_d    = oovf_q;
    out_vld_d = (out_vld_q && !out_stall_i) ? 1'b0 : out_vld_q;

    unique case (state_q)
      edp_pkg::BK_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o   = 1'b1;
          sum_d   = pop_data_i.sum;
          ovf_d   = pop_data_i.ovf;
          rem_d   = pop_data_i.sum;
          res_d   = '0;
          bit_d   = BitInit;
          state_d = edp_pkg::BK_RUN;
        end
      end
      edp_pkg::BK_RUN: begin
        if (rem_ext >= trial) begin
          rem_d = edp_pkg::AccW'(rem_ext - trial);
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q == edp_pkg::RootW'(1)) begin
          state_d = edp_pkg::BK_DONE;
        end
      end
      edp_pkg::BK_DONE: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          dist_d    = res_q[edp_pkg::DistW-1:0];
          osum_d    = sum_q;
          oovf_d    = ovf_q;
          state_d   = edp_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = edp_pkg::BK_IDLE;
      end
    endcase
  end

  assign out_valid_o      = out_vld_q;
  assign distance_o       = dist_q;
  assign sum_of_squares_o = osum_q;
  assign overflow_o       = oovf_q;

endmodule

@@ rtl/euclidean_distance_padded.sv @@
// Top level of the padded Euclidean distance block: front, queue and root back end.
//
//   channel  dir  handshake                fields
//   in       in   in_valid_i / in_stall_o   a_elem_i b_elem_i a_present_i b_present_i last_i
//   out      out  out_valid_o / out_stall_i distance_o sum_of_squares_o overflow_o
//
// The front takes one component request per cycle while in_stall_o is low: a subtract
// and 17x17 square, then a saturating 38-bit accumulate one stage later.
// Each vector end goes into a two-entry queue; the back end runs a 20-step
// bit-pair square root (one result bit per cycle). Back-to-back vectors
// that arrive faster than the root finishes them fill the queue and then
// stall the input.
// Reset (rst_ni, async, active low) clears the sum, element count, queue and
// output valid; a valid result in the output register holds while out_stall_i is high.
module euclidean_distance_padded #(
  parameter int unsigned MAX_DIM = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input requests
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [edp_pkg::ElemW-1:0] a_elem_i,
  input  logic signed [edp_pkg::ElemW-1:0] b_elem_i,
  input  logic                             a_present_i,
  input  logic                             b_present_i,
  input  logic                             last_i,
  // result requests
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [edp_pkg::DistW-1:0]        distance_o,
  output logic [edp_pkg::AccW-1:0]         sum_of_squares_o,
  output logic                             overflow_o
);

  // front -> queue
  logic              push;
  edp_pkg::vec_sum_t push_data;
  // queue -> back
  logic              pop;
  edp_pkg::vec_sum_t pop_data;
  edp_pkg::q_stat_t  q_stat;

  edp_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .a_elem_i    (a_elem_i),
    .b_elem_i    (b_elem_i),
    .a_present_i (a_present_i),
    .b_present_i (b_present_i),
    .last_i      (last_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // decouples accumulation from the multi-cycle root
  edp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  edp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_stat_i         (q_stat),
    .pop_data_i       (pop_data),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .distance_o       (distance_o),
    .sum_of_squares_o (sum_of_squares_o),
    .overflow_o       (overflow_o)
  );

endmodule

@@ tb/sv/euclidean_distance_padded_test.sv @@
// Self-checking testbench for the padded Euclidean distance block.
`timescale 1ns / 100ps

module euclidean_distance_padded_test;

  localparam int unsigned VecMax = 64;

  // one expected distance result
  typedef struct packed {
    logic [edp_pkg::DistW-1:0] distance;
    logic [edp_pkg::AccW-1:0]  sum;
    logic                      overflow;
  } dist_result_t;

  logic                             clk_i;
  logic                             rst_ni       = 1'b0;
  logic                             in_valid_i   = 1'b0;
  logic                             in_stall_o;
  logic signed [edp_pkg::ElemW-1:0] a_elem_i     = '0;
  logic signed [edp_pkg::ElemW-1:0] b_elem_i     = '0;
  logic                             a_present_i  = 1'b0;
  logic                             b_present_i  = 1'b0;
  logic                             last_i       = 1'b0;
  logic                             out_valid_o;
  logic                             out_stall_i  = 1'b0;
  logic [edp_pkg::DistW-1:0]        distance_o;
  logic [edp_pkg::AccW-1:0]         sum_of_squares_o;
  logic                             overflow_o;

  // Predictor state: running sum of squares, component count and the
  // sticky too-many-components flag of the vector in flight.
  logic [edp_pkg::AccW-1:0] sum_acc;
  int unsigned              comp_count;
  logic                     dim_overflow;

  dist_result_t    pending_distances[$];
  int unsigned     err_count;
  int unsigned     sent_count;

  // Idling odds in percent, changed per phase from the test sequence.
  int unsigned     send_idle_pct;
  int unsigned     stall_pct;

  euclidean_distance_padded #(
    .MAX_DIM(VecMax)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .a_elem_i        (a_elem_i),
    .b_elem_i        (b_elem_i),
    .a_present_i     (a_present_i),
    .b_present_i     (b_present_i),
    .last_i          (last_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .distance_o      (distance_o),
    .sum_of_squares_o(sum_of_squares_o),
    .overflow_o      (overflow_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Bit-pair integer square root; floor(sqrt(sum)) is already an unsigned 19-bit integer (Q19.0).
  function automatic logic [edp_pkg::DistW-1:0] floor_root(logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] pair;
    rem  = x;
    res  = '0;
    pair = 64'd1 << 38;
    while (pair > x && pair != 0) pair = pair >> 2;
    while (pair != 0) begin
      if (rem >= res + pair) begin
        rem = rem - (res + pair);
        res = (res >> 1) + pair;
      end else begin
        res = res >> 1;
      end
      pair = pair >> 2;
    end
    return res[edp_pkg::DistW-1:0];
  endfunction

  function automatic void clear_vector();
    sum_acc      = '0;
    comp_count   = 0;
    dim_overflow = 1'b0;
  endfunction

  // Fold one accepted component request into the predictor; a last request
  // queues the expected result and starts a fresh vector.
  function automatic void accumulate_component(logic signed [edp_pkg::ElemW-1:0] a,
                                               logic signed [edp_pkg::ElemW-1:0] b,
                                               logic ap, logic bp, logic lst);
    logic signed [edp_pkg::ElemW:0] av;
    logic signed [edp_pkg::ElemW:0] bv;
    logic signed [edp_pkg::ElemW:0] diff;
    logic [edp_pkg::ElemW:0]        mag;
    logic [2*edp_pkg::ElemW+1:0]    sq;
    logic [edp_pkg::AccW:0]         total;
    dist_result_t                   res;
    // absent component counts as zero (padding)
    av   = ap ? {a[edp_pkg::ElemW-1], a} : '0;
    bv   = bp ? {b[edp_pkg::ElemW-1], b} : '0;
    diff = av - bv;
    mag  = diff[edp_pkg::ElemW] ? -diff : diff;
    sq   = mag * mag;
    if (comp_count >= VecMax) begin
      dim_overflow = 1'b1;
      sum_acc      = edp_pkg::AccMax;
    end else begin
      comp_count++;
      if (!dim_overflow) begin
        // sum saturates on its own without raising overflow
        total   = {1'b0, sum_acc} + (edp_pkg::AccW + 1)'(sq);
        sum_acc = total[edp_pkg::AccW] ? edp_pkg::AccMax : total[edp_pkg::AccW-1:0];
      end
    end
    if (lst) begin
      res.distance = floor_root(64'(sum_acc));
      res.sum      = sum_acc;
      res.overflow = dim_overflow;
      pending_distances.push_back(res);
      clear_vector();
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  // Send one component request and hold it until accepted; the sender may
  // idle first, per the current phase odds.
  task automatic send_component(logic signed [edp_pkg::ElemW-1:0] a,
                                logic signed [edp_pkg::ElemW-1:0] b,
                                logic ap, logic bp, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    a_elem_i    <= a;
    b_elem_i    <= b;
    a_present_i <= ap;
    b_present_i <= bp;
    last_i      <= lst;
    do @(posedge clk_i); while (in_stall_o);
    accumulate_component(a, b, ap, bp, lst);
    sent_count++;
  endtask

  // Extremes and zero three times in eight, otherwise anything.
  function automatic logic signed [edp_pkg::ElemW-1:0] pick_elem();
    case ($urandom_range(7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      default: return edp_pkg::ElemW'($urandom);
    endcase
  endfunction

  // Well-formed vector of len components: random with padding, or max_diff.
  task automatic send_vector(int unsigned len, bit max_diff);
    logic ap;
    logic bp;
    for (int unsigned i = 0; i < len; i++) begin
      ap = ($urandom_range(99) < 80);
      bp = ($urandom_range(99) < 80);
      if (max_diff)
        send_component(16'sh7FFF, 16'sh8000, 1'b1, 1'b1, i == len - 1);
      else
        send_component(pick_elem(), pick_elem(), ap, bp, i == len - 1);
    end
  endtask

  // Largest diffs both ways, equal extremes, max vs zero, +1 vs -1, all-zero.
  task automatic test_extreme_pairs();
    send_component(16'sh7FFF, 16'sh8000, 1'b1, 1'b1, 1'b1);
    send_component(16'sh8000, 16'sh7FFF, 1'b1, 1'b1, 1'b1);
    send_component(16'sh8000, 16'sh8000, 1'b1, 1'b1, 1'b1);
    send_component(16'sh7FFF, 16'sh0000, 1'b1, 1'b1, 1'b1);
    send_component(16'sh0000, 16'sh0000, 1'b1, 1'b1, 1'b1);
    send_component(16'sh0001, 16'shFFFF, 1'b1, 1'b1, 1'b1);
  endtask

  // Absent components read as zero whatever the data lines carry; a pair
  // with both absent still counts toward the dimension.
  task automatic test_absent_components();
    send_component(16'sh7FFF, 16'sh8000, 1'b0, 1'b0, 1'b1);
    send_component(16'sh8000, 16'sh7FFF, 1'b1, 1'b0, 1'b1);
    send_component(16'sh8000, 16'sh7FFF, 1'b0, 1'b1, 1'b1);
    send_component(16'sh1234, 16'sh5678, 1'b0, 1'b0, 1'b0);
    send_component(16'shFFFF, 16'sh0100, 1'b1, 1'b1, 1'b1);
  endtask

  // A four-component vector, then a second with a single, a-absent component.
  task automatic test_short_second_vector();
    send_component(16'sh0300, 16'sh0100, 1'b1, 1'b1, 1'b0);
    send_component(16'sh8000, 16'sh7FFF, 1'b1, 1'b0, 1'b0);
    send_component(16'sh7FFF, 16'sh8000, 1'b1, 1'b0, 1'b0);
    send_component(16'shC000, 16'sh2222, 1'b1, 1'b0, 1'b1);
    send_component(16'sh0000, 16'sh4000, 1'b0, 1'b1, 1'b1);
  endtask

  // Around the dimension limit: one short, full length, one and two past and
  // well past, then a short vector to see the state cleared. At this limit the
  // sum cannot saturate by size alone, only by too many components.
  task automatic test_dimension_overflow();
    send_vector(VecMax, 1'b1);
    send_vector(VecMax - 1, 1'b0);
    send_vector(VecMax, 1'b0);
    send_vector(VecMax + 1, 1'b1);
    send_vector(VecMax + 1, 1'b0);
    send_vector(VecMax + 2, 1'b0);
    send_vector(VecMax + 16, 1'b0);
    send_vector(1, 1'b0);
  endtask

  // Random vectors, mostly short so many results come back; some long ones
  // reach and pass the dimension limit.
  task automatic test_random_vectors(int unsigned n_items);
    int unsigned goal;
    int unsigned pick;
    goal = sent_count + n_items;
    while (sent_count < goal) begin
      pick = $urandom_range(99);
      if (pick < 85)
        send_vector($urandom_range(1, 8), 1'b0);
      else if (pick < 96)
        send_vector($urandom_range(9, VecMax), 1'b0);
      else
        send_vector($urandom_range(VecMax + 1, VecMax + 12), 1'b0);
    end
  endtask

  // Receiver: random stall, and each accepted result checked against the
  // oldest expectation. Outputs and stall are sampled before this edge updates.
  always @(posedge clk_i) begin
    dist_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_distances.size() == 0) begin
        report_mismatch("unexpected result, distance", 64'(distance_o), 64'(0));
      end else begin
        want = pending_distances.pop_front();
        if (distance_o !== want.distance)
          report_mismatch("distance", 64'(distance_o), 64'(want.distance));
        if (sum_of_squares_o !== want.sum)
          report_mismatch("sum_of_squares", 64'(sum_of_squares_o), 64'(want.sum));
        if (overflow_o !== want.overflow)
          report_mismatch("overflow", 64'(overflow_o), 64'(want.overflow));
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    err_count     = 0;
    sent_count    = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    clear_vector();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, no idling
    test_extreme_pairs();
    test_absent_components();
    test_short_second_vector();

    // random part across idling phases
    test_random_vectors(290);
    send_idle_pct = 86;
    test_random_vectors(290);
    send_idle_pct = 0;
    stall_pct     = 86;
    test_random_vectors(290);
    send_idle_pct = 32;
    stall_pct     = 32;
    test_random_vectors(290);
    test_dimension_overflow();

    in_valid_i <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk_i);
    // one square-root pass plus margin for anything still in flight
    repeat (40) @(posedge clk_i);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
